/* rtl/core/wsd_pkg.sv */
`default_nettype none

package wsd_pkg;

  // Parser phases.
  localparam logic [2:0] PH_HDR0    = 3'd0;
  localparam logic [2:0] PH_HDR1    = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_MASK    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  localparam int unsigned LenW = 63;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  // Extended length and mask key byte counts; zero wraps to mean eight bytes.
  localparam logic [2:0] EXT16_BYTES = 3'd2;
  localparam logic [2:0] EXT64_BYTES = 3'd0;
  localparam logic [2:0] MASK_BYTES  = 3'd4;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic [7:0]      data_byte;
    logic            has_data;
    logic            fin_flag;
    logic [3:0]      frame_opcode;
    logic [LenW-1:0] payload_length;
    logic            last_in_frame;
  } result_t;

endpackage

`default_nettype wire

/* rtl/core/wsd_stream_if.sv */
`default_nettype none

interface wsd_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/core/wsd_parser.sv */
`default_nettype none

module wsd_parser (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire wsd_pkg::byte_t  byte_i,
  output logic                 res_valid_o,
  output wsd_pkg::result_t     res_o
);
  import wsd_pkg::*;

  logic [2:0]      phase_q, phase_d;
  logic            fin_q, fin_d;
  logic [3:0]      opc_q, opc_d;
  logic            mask_on_q, mask_on_d;
  logic [2:0]      cnt_q, cnt_d;
  logic [LenW-1:0] len_q, len_d;
  logic [3:0][7:0] key_q, key_d;
  logic [LenW-1:0] rem_q, rem_d;
  logic [1:0]      idx_q, idx_d;

  logic       len_done;
  logic       hdr_done;
  logic       emit;
  logic [7:0] key_byte;

  always_comb begin
    phase_d   = phase_q;
    fin_d     = fin_q;
    opc_d     = opc_q;
    mask_on_d = mask_on_q;
    cnt_d     = cnt_q;
    len_d     = len_q;
    key_d     = key_q;
    rem_d     = rem_q;
    idx_d     = idx_q;
    len_done  = 1'b0;
    hdr_done  = 1'b0;
    emit      = 1'b0;
    // Key bytes are used most significant first.
    key_byte  = key_q[2'd3 - idx_q];
    res_o     = '0;

    unique case (phase_q)
      PH_HDR1: begin
        mask_on_d = byte_i[7];
        key_d     = '0;
        cnt_d     = '0;
        if (byte_i[6:0] == LEN7_EXT16 || byte_i[6:0] == LEN7_EXT64) begin
          len_d   = '0;
          cnt_d   = (byte_i[6:0] == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
          phase_d = PH_EXTLEN;
        end else begin
          len_d    = {{(LenW-7){1'b0}}, byte_i[6:0]};
          len_done = 1'b1;
        end
      end
      PH_EXTLEN: begin
        // Shifting through 63 bits drops the top bit of a 64-bit length.
        len_d = {len_q[LenW-9:0], byte_i};
        cnt_d = cnt_q - 3'd1;
        if (cnt_d == '0) begin
          len_done = 1'b1;
        end
      end
      PH_MASK: begin
        key_d = {key_q[2:0], byte_i};
        cnt_d = cnt_q + 3'd1;
        if (cnt_d == MASK_BYTES) begin
          cnt_d    = '0;
          hdr_done = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        idx_d = idx_q + 2'd1;
        rem_d = rem_q - {{(LenW-1){1'b0}}, 1'b1};
        emit  = 1'b1;
        res_o.data_byte     = byte_i ^ key_byte;
        res_o.has_data      = 1'b1;
        res_o.last_in_frame = (rem_d == '0);
        if (rem_d == '0) begin
          phase_d = PH_HDR0;
        end
      end
      default: begin
        fin_d   = byte_i[7];
        opc_d   = byte_i[3:0];
        phase_d = PH_HDR1;
      end
    endcase

    if (len_done) begin
      if (mask_on_d) begin
        cnt_d   = '0;
        phase_d = PH_MASK;
      end else begin
        hdr_done = 1'b1;
      end
    end

    if (hdr_done) begin
      if (len_d == '0) begin
        // An empty frame still yields one marker transaction.
        emit                = 1'b1;
        res_o.last_in_frame = 1'b1;
        phase_d             = PH_HDR0;
      end else begin
        rem_d   = len_d;
        idx_d   = '0;
        phase_d = PH_PAYLOAD;
      end
    end

    res_o.fin_flag       = fin_q;
    res_o.frame_opcode   = opc_q;
    res_o.payload_length = len_d;
  end

  assign res_valid_o = step_i && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HDR0;
      fin_q     <= 1'b0;
      opc_q     <= '0;
      mask_on_q <= 1'b0;
      cnt_q     <= '0;
      len_q     <= '0;
      key_q     <= '0;
      rem_q     <= '0;
      idx_q     <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      fin_q     <= fin_d;
      opc_q     <= opc_d;
      mask_on_q <= mask_on_d;
      cnt_q     <= cnt_d;
      len_q     <= len_d;
      key_q     <= key_d;
      rem_q     <= rem_d;
      idx_q     <= idx_d;
    end
  end

  a_marker_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.has_data |->
      res_o.last_in_frame && res_o.data_byte == '0 && res_o.payload_length == '0)
    else $error("empty-frame marker carries data");

  a_payload_has_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> rem_q != '0 && len_q != '0)
    else $error("payload phase with nothing left to receive");

  a_phase_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PH_PAYLOAD)
    else $error("parser phase left the defined codes");

endmodule

`default_nettype wire

/* rtl/core/websocket_frame_deframer.sv */
// WebSocket frame deframer: takes the raw stream one byte per transaction
// and returns one transaction per payload byte, unmasked, tagged with the
// frame's FIN bit, opcode and 63-bit length, with the final byte marked;
// an empty frame returns a single marker with has_data low. Other header
// and mask key bytes return nothing. The block accepts one byte every cycle
// unless the receiver stalls: an input register feeds the header/payload
// parser, whose state update loads the output register. A stalled receiver
// holds the parser, so once both registers are full the input stalls in the
// same cycle. No clearing pass is needed after reset.
`default_nettype none

module websocket_frame_deframer (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  wsd_stream_if.sink   byte_in,
  wsd_stream_if.source frame_out
);
  import wsd_pkg::*;

  logic    in_vld_q;
  byte_t   in_byte_q;
  logic    out_vld_q;
  result_t out_q;

  logic    advance;
  logic    step;
  logic    res_valid;
  result_t res;

  assign advance       = !out_vld_q || frame_out.ready;
  assign step          = in_vld_q && advance;
  assign byte_in.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (byte_in.ready) begin
      in_vld_q <= byte_in.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_in.ready && byte_in.valid) begin
      in_byte_q <= byte_in.payload;
    end
  end

  wsd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign frame_out.valid   = out_vld_q;
  assign frame_out.payload = out_q;

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |=> in_vld_q && $stable(in_byte_q))
    else $error("input register lost a byte while stalled");

  a_res_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |=> out_vld_q)
    else $error("parser result not captured");

  a_res_only_on_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> in_vld_q && advance)
    else $error("result produced without a byte");

endmodule

`default_nettype wire
